// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the angular sector classifier RTL.
// Requires a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, suspended while reset is high
`define ASC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property, also checked during reset
`define ASC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/asc_pkg.sv =====
// Package for the angular sector classifier: codes, field widths, shared types.
// No dependencies.
`timescale 1ns / 1ps

package asc_pkg;

   // Opcode of an input beat
   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 2'd1;

   // Field widths
   localparam int FIELD_W    = 16;
   localparam int ROW_IDX_W  = 4;
   localparam int MASK_W     = 16;
   localparam int MASK_IDX_W = 4;
   localparam int COUNT_W    = 5;
   localparam int TOL_W      = 16;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
   localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd1049;

   // Per-cell control
   typedef struct packed {
      logic load;   // copy the stored row into the shift stage
      logic write;  // store a new row
   } cell_ctl_type;

endpackage

// ===== hw/rtl/asc_cell.sv =====
// One cell of the region chain: stores one table row and a shift stage.
// Depends on asc_pkg.
`timescale 1ns / 1ps

module asc_cell #(
   parameter int ROW_W = 64
) (
   input  logic                clock,
   input  asc_pkg::cell_ctl_type ctl,
   input  logic [ROW_W-1:0]    wr_row,
   input  logic [ROW_W-1:0]    pass_in,
   output logic [ROW_W-1:0]    pass_out
);

   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [ROW_W-1:0] pass_ff;
   logic [ROW_W-1:0] pass_in_sel;

   // Stored row, written by index
   assign row_in = ctl.write ? wr_row : row_ff;

   // Shift stage: load own row at start of a classify, else take neighbor's
   assign pass_in_sel = ctl.load ? row_ff : pass_in;

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      pass_ff <= pass_in_sel;
   end

   assign pass_out = pass_ff;

endmodule

// ===== hw/rtl/asc_eval.sv =====
// Shared boundary evaluator at the head of the chain: four products, then compares.
// Depends on asc_pkg.
`timescale 1ns / 1ps

module asc_eval #(
   parameter int CW = 16
) (
   input  logic                          clock,
   input  logic [4*CW-1:0]               row_in,
   input  logic signed [asc_pkg::FIELD_W-1:0] vx,
   input  logic signed [asc_pkg::FIELD_W-1:0] vy,
   input  logic [asc_pkg::TOL_W-1:0]     tol,
   output logic                          hit
);

   localparam int P = CW + asc_pkg::FIELD_W;
   localparam int S = P + 2;

   logic signed [CW-1:0] coef_a;
   logic signed [CW-1:0] coef_b;
   logic signed [CW-1:0] coef_c;
   logic signed [CW-1:0] coef_d;

   logic signed [P-1:0] prod_ay_ff;
   logic signed [P-1:0] prod_bx_ff;
   logic signed [P-1:0] prod_cy_ff;
   logic signed [P-1:0] prod_dx_ff;

   logic signed [S-1:0] tol_s;
   logic signed [S-1:0] upper_rhs;
   logic signed [S-1:0] lower_rhs;

   // Row layout: {a, b, c, d}
   assign coef_a = row_in[4*CW-1:3*CW];
   assign coef_b = row_in[3*CW-1:2*CW];
   assign coef_c = row_in[2*CW-1:CW];
   assign coef_d = row_in[CW-1:0];

   // Product stage
   always_ff @(posedge clock) begin
      prod_ay_ff <= P'(coef_a) * P'(vy);
      prod_bx_ff <= P'(coef_b) * P'(vx);
      prod_cy_ff <= P'(coef_c) * P'(vy);
      prod_dx_ff <= P'(coef_d) * P'(vx);
   end

   // Compare stage: c*vy <= d*vx + tol and a*vy >= b*vx - tol
   assign tol_s     = S'($signed({1'b0, tol}));
   assign upper_rhs = S'(prod_dx_ff) + tol_s;
   assign lower_rhs = S'(prod_bx_ff) - tol_s;
   assign hit = (S'(prod_cy_ff) <= upper_rhs) && (S'(prod_ay_ff) >= lower_rhs);

endmodule

// ===== hw/rtl/angular_sector_classifier_core.sv =====
// Top level of the angular sector classifier: sequencer, config registers, cell chain.
// Depends on asc_pkg, asc_cell, asc_eval and assert_macros.svh.
`timescale 1ns / 1ps
//
// Channel | Direction | Handshake            | Beat
// req     | in        | req_valid/req_ready  | row write or classify vector
// rsp     | out       | rsp_valid/rsp_ready  | region mask and none-found flag
// csr     | in        | csr_valid/csr_ready  | register index and data
//
// A row write is stored when accepted and gives no response beat. A classify
// loads every row of the N = min(MAX_REGIONS, 16) cells into the chain, which
// then shifts one row per cycle into the shared four-multiplier evaluator;
// its product registers feed the compares into the mask register, from which
// the result is loaded; req_ready returns as the result enters the output register.
// req_ready is high only while idle; a finished result waits in the sequencer
// until the output register is free, so a stalled rsp holds the next classify.
// Synchronous reset clears control registers and sets the config registers to
// their reset values; the row table is not cleared.

`include "assert_macros.svh"

module angular_sector_classifier_core #(
   parameter int MAX_REGIONS = 16,
   parameter int COEF_WIDTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [asc_pkg::ROW_IDX_W-1:0]       req_row_index,
   input  logic signed [asc_pkg::FIELD_W-1:0]  req_coef_lower_y,
   input  logic signed [asc_pkg::FIELD_W-1:0]  req_coef_lower_x,
   input  logic signed [asc_pkg::FIELD_W-1:0]  req_coef_upper_y,
   input  logic signed [asc_pkg::FIELD_W-1:0]  req_coef_upper_x,
   input  logic signed [asc_pkg::FIELD_W-1:0]  req_x_velocity,
   input  logic signed [asc_pkg::FIELD_W-1:0]  req_y_velocity,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [asc_pkg::MASK_W-1:0]          rsp_region_mask,
   output logic                                rsp_none_found,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [asc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [asc_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Rows beyond the mask width can never be written or examined
   localparam int NCELL = (MAX_REGIONS < asc_pkg::MASK_W) ? MAX_REGIONS : asc_pkg::MASK_W;
   localparam int CW    = (COEF_WIDTH < asc_pkg::FIELD_W) ? COEF_WIDTH : asc_pkg::FIELD_W;
   localparam int ROW_W = 4 * CW;
   localparam int IDX_W = $clog2(NCELL);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCELL - 1);

   // Sequencer codes
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] pidx_ff;
   logic pv_ff;
   logic [asc_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic signed [asc_pkg::FIELD_W-1:0] vx_ff, vy_ff;
   logic [asc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [asc_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [asc_pkg::MASK_W-1:0] rsp_mask_ff;
   logic rsp_none_ff;

   logic req_fire, csr_fire, start, finish_fire, hit, in_count;
   logic [asc_pkg::COUNT_W-1:0] count_eff;
   logic [ROW_W-1:0] wr_row;
   logic [ROW_W-1:0] pass_w [NCELL];

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign req_fire    = req_valid && req_ready;
   assign csr_fire    = csr_valid && csr_ready;
   assign start       = req_fire && (req_opcode == asc_pkg::OP_CLASSIFY);
   assign finish_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Configuration registers
   always_comb begin
      count_in = count_ff;
      tol_in   = tol_ff;
      if (csr_fire) begin
         unique case (csr_index)
            asc_pkg::CSR_REGION_COUNT: count_in = csr_data[asc_pkg::COUNT_W-1:0];
            asc_pkg::CSR_TOLERANCE:    tol_in   = csr_data[asc_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Row write data, each coefficient cut to the stored width
   assign wr_row = {req_coef_lower_y[CW-1:0], req_coef_lower_x[CW-1:0],
                    req_coef_upper_y[CW-1:0], req_coef_upper_x[CW-1:0]};

   // Cell chain; the head feeds the evaluator
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      asc_pkg::cell_ctl_type ctl;
      logic [ROW_W-1:0] nbr;
      assign ctl.load  = start;
      assign ctl.write = req_fire && (req_opcode == asc_pkg::OP_WRITE) &&
                         (req_row_index == asc_pkg::ROW_IDX_W'(i));
      if (i == NCELL - 1) begin : g_tail
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = pass_w[i+1];
      end
      asc_cell #(.ROW_W(ROW_W)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .wr_row   (wr_row),
         .pass_in  (nbr),
         .pass_out (pass_w[i])
      );
   end

   asc_eval #(.CW(CW)) u_eval (
      .clock  (clock),
      .row_in (pass_w[0]),
      .vx     (vx_ff),
      .vy     (vy_ff),
      .tol    (tol_ff),
      .hit    (hit)
   );

   // Examined count saturates at the chain length
   assign count_eff = (count_ff > asc_pkg::COUNT_W'(NCELL)) ?
                      asc_pkg::COUNT_W'(NCELL) : count_ff;
   assign in_count  = (asc_pkg::COUNT_W'(pidx_ff) < count_eff);

   // Sequencer and mask accumulation
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mask_in  = mask_ff;
      if (pv_ff && hit && in_count) begin
         mask_in[asc_pkg::MASK_IDX_W'(pidx_ff)] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               mask_in  = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (finish_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= asc_pkg::COUNT_RESET;
         tol_ff       <= asc_pkg::TOL_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= (state_ff == ST_RUN);
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pidx_ff <= cnt_ff;
      mask_ff <= mask_in;
      if (start) begin
         vx_ff <= req_x_velocity;
         vy_ff <= req_y_velocity;
      end
      if (finish_fire) begin
         rsp_mask_ff <= mask_ff;
         rsp_none_ff <= (mask_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_region_mask = rsp_mask_ff;
   assign rsp_none_found  = rsp_none_ff;

   // Checks
   `ASC_ASSERT(a_busy_not_ready, (state_ff != ST_IDLE) |-> !req_ready, "req_ready while busy")
   `ASC_ASSERT(a_none_flag, rsp_valid |-> (rsp_none_found == (rsp_region_mask == '0)), "none_found mismatch")
   `ASC_ASSERT(a_run_to_drain, (state_ff == ST_RUN && cnt_ff == LAST_IDX) |=> (state_ff == ST_DRAIN), "chain sweep did not end")
   `ASC_ASSERT_ALWAYS(a_product_in_sweep, pv_ff |-> (state_ff == ST_RUN || state_ff == ST_DRAIN), "product stage valid outside sweep")

endmodule
